/* rtl/core/group_norm_backward_defines.svh */
// Assertion macros for the group normalisation backward block.
// Included by the top level; defining ASSERT_OFF leaves the macros empty.
`ifndef GROUP_NORM_BACKWARD_DEFINES_SVH
`define GROUP_NORM_BACKWARD_DEFINES_SVH
`ifndef ASSERT_OFF
`define GNB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("group_norm_backward: assertion failed");
`define GNB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("group_norm_backward: assertion failed");
`else
`define GNB_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GNB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/gnb_pkg.sv */
// Shared types, codes and helper functions of the group normalisation backward block.
// No dependencies.
package gnb_pkg;

   localparam int MAX_CHANNELS_DEF       = 256;
   localparam int MAX_GROUP_ELEMENTS_DEF = 1048576;

   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_ACCUM = 3'd1,
      OP_EMIT  = 3'd2,
      OP_READ  = 3'd3,
      OP_CLEAR = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_EPSILON   = 2'd0,
      CSR_USE_SCALE = 2'd1,
      CSR_USE_BIAS  = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      ACT_NONE,
      ACT_GRP_CLR,
      ACT_MEM_RD,
      ACT_CH_CLR,
      ACT_READ_OUT,
      ACT_XHAT,
      ACT_ACC_DOTS,
      ACT_ACC_DOTB,
      ACT_ACC_STORE,
      ACT_TAKE_Q,
      ACT_HOLD_HI,
      ACT_T2,
      ACT_TAKE_T3,
      ACT_NUM1,
      ACT_NUM2,
      ACT_DX,
      ACT_DX_VZ,
      ACT_OUT
   } act_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_DIFF_DY,
      MUL_DY_S,
      MUL_X_DY,
      MUL_QHI_X,
      MUL_QLO_X,
      MUL_NHI_R,
      MUL_NLO_R
   } msel_type;

   typedef enum logic [1:0] {
      DIV_XHAT,
      DIV_DOTS,
      DIV_DOTB,
      DIV_ROOT
   } dsel_type;

   typedef enum logic [5:0] {
      S_IDLE, S_DISPATCH, S_GCLR, S_RRD, S_ROUT, S_CCLR,
      S_XDIV, S_XWAIT, S_XHAT,
      S_AM1, S_AM2, S_AM3, S_AWR,
      S_EDS, S_EWS, S_ETQ, S_EM1, S_EM2, S_ET2,
      S_EDB, S_EWB, S_ETB, S_EN1, S_EN2,
      S_EDR, S_EWR, S_ESQ, S_EWQ, S_EM4, S_EM5, S_EDX, S_EVZ,
      S_DONE
   } state_type;

   typedef struct packed {
      logic     load;
      act_type  act;
      msel_type msel;
      logic     div_go;
      dsel_type dsel;
      logic     sqrt_go;
   } cmd_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic       s_zero;
      logic       v_zero;
      logic       div_busy;
      logic       sqrt_busy;
      logic       out_free;
   } sts_type;

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return s[63:0];
   endfunction

   function automatic logic [63:0] sat_sub64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return s[63:0];
   endfunction

endpackage

/* rtl/core/gnb_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle, 64 by 32 bits.
// No dependencies.
module gnb_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [63:0] quotient
);
   localparam int STEPS = 64;
   localparam int CNTW  = $clog2(STEPS);

   logic [63:0]     quo_ff;
   logic [32:0]     rem_ff;
   logic [31:0]     den_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff;
   logic [32:0]     rem_sh;
   logic            fits;
   logic [32:0]     rem_in;

   assign rem_sh = {rem_ff[31:0], quo_ff[63]};
   assign fits   = rem_sh >= {1'b0, den_ff};
   assign rem_in = fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (go) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == CNTW'(STEPS - 1)) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[62:0], fits};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + CNTW'(1);
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

/* rtl/core/gnb_sqrt.sv */
// Digit-by-digit integer square root of a 49-bit operand, two operand bits a cycle.
// No dependencies.
module gnb_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [48:0] radicand,
   output logic        busy,
   output logic [24:0] root
);
   logic [48:0] x_ff;
   logic [49:0] res_ff;
   logic [48:0] bit_ff;
   logic [49:0] trial;
   logic        take;

   assign trial = res_ff + {1'b0, bit_ff};
   assign take  = {1'b0, x_ff} >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else if (go) begin
         bit_ff <= 49'h1_0000_0000_0000;
      end else begin
         bit_ff <= bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         x_ff   <= radicand;
         res_ff <= '0;
      end else if (bit_ff != '0) begin
         if (take) begin
            x_ff   <= x_ff - trial[48:0];
            res_ff <= (res_ff >> 1) + {1'b0, bit_ff};
         end else begin
            res_ff <= res_ff >> 1;
         end
      end
   end

   assign busy = bit_ff != '0;
   assign root = res_ff[24:0];
endmodule

/* rtl/core/gnb_datapath.sv */
// Datapath: operand registers, shared multiplier, divider and root units, gradient stores.
// Depends on gnb_pkg, gnb_divider and gnb_sqrt.
module gnb_datapath import gnb_pkg::*; #(
   parameter int MAX_CHANNELS       = MAX_CHANNELS_DEF,
   parameter int MAX_GROUP_ELEMENTS = MAX_GROUP_ELEMENTS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output sts_type       sts,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata,
   input  logic [2:0]    opcode,
   input  logic [31:0]   y_value,
   input  logic [31:0]   dy_value,
   input  logic [31:0]   channel_scale,
   input  logic [31:0]   channel_bias,
   input  logic [7:0]    channel_index,
   input  logic [30:0]   group_variance,
   input  logic          rsp_tready,
   output logic          rsp_tvalid,
   output logic [31:0]   dx_value,
   output logic [63:0]   channel_grad_scale,
   output logic [63:0]   channel_grad_bias
);
   localparam int CW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNTW = $clog2(MAX_GROUP_ELEMENTS + 1);

   localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [31:0] MIN32 = 32'h8000_0000;
   localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;

   function automatic logic [31:0] mag32(input logic [31:0] x);
      return x[31] ? (~x + 32'd1) : x;
   endfunction

   function automatic logic [63:0] mag64(input logic [63:0] x);
      return x[63] ? (~x + 64'd1) : x;
   endfunction

   logic [15:0] eps_ff;
   logic        use_scale_ff;
   logic        use_bias_ff;

   logic [2:0]  op_ff;
   logic [31:0] dy_ff;
   logic [31:0] s_ff;
   logic [31:0] diff_ff;
   logic [7:0]  ch_ff;
   logic [31:0] v_ff;
   logic [31:0] xhat_ff;

   logic [63:0]     dots_ff;
   logic [63:0]     dotb_ff;
   logic [CNTW-1:0] cnt_ff;

   logic [63:0] prod_ff;
   logic        prod_neg_ff;
   logic [63:0] hi_ff;
   logic [63:0] qmag_ff;
   logic        qneg_ff;
   logic [63:0] t2_ff;
   logic [63:0] t3_ff;
   logic [63:0] num_ff;

   logic [31:0] dx_ff;
   logic [63:0] gs_ff;
   logic [63:0] gb_ff;

   logic         rsp_vld_ff;
   logic [159:0] rsp_data_ff;

   logic [63:0]       scale_mem [MAX_CHANNELS];
   logic [63:0]       bias_mem  [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] vld_ff;
   logic [63:0]       rd_s_ff;
   logic [63:0]       rd_b_ff;
   logic              rd_v_ff;

   logic [15:0]   ch_ext;
   logic [CW-1:0] idx;
   logic          ch_ok;

   logic [31:0] s_in;
   logic [31:0] b_in;
   logic [32:0] diff_wide;
   logic [31:0] diff_in;

   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic        mul_neg;
   logic [63:0] psig;
   logic [63:0] xabs;
   logic [63:0] nmag;

   logic        div_go;
   logic [63:0] div_dividend;
   logic [31:0] div_divisor;
   logic        div_busy;
   logic [63:0] div_q;
   logic        sqrt_busy;
   logic [24:0] root;
   logic [31:0] n_val;

   logic [31:0] xhat_in;
   logic [63:0] t2_in;
   logic [63:0] t3_in;
   logic [31:0] dx_in;
   logic [31:0] dx_vz_in;
   logic [63:0] old_s;
   logic [63:0] old_b;
   logic [63:0] dy_q32;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff       <= 16'd1;
         use_scale_ff <= 1'b1;
         use_bias_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EPSILON:   eps_ff       <= csr_wdata;
            CSR_USE_SCALE: use_scale_ff <= csr_wdata[0];
            CSR_USE_BIAS:  use_bias_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign s_in      = use_scale_ff ? channel_scale : 32'h0001_0000;
   assign b_in      = use_bias_ff ? channel_bias : 32'd0;
   assign diff_wide = {y_value[31], y_value} - {b_in[31], b_in};
   assign diff_in   = (diff_wide[32] != diff_wide[31]) ? (diff_wide[32] ? MIN32 : MAX32)
                                                       : diff_wide[31:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= opcode;
         dy_ff   <= dy_value;
         s_ff    <= s_in;
         diff_ff <= diff_in;
         ch_ff   <= channel_index;
         v_ff    <= 32'(group_variance) + 32'(eps_ff);
      end
   end

   assign ch_ext = {8'd0, ch_ff};
   assign idx    = ch_ext[CW-1:0];
   assign ch_ok  = ch_ext < 16'(MAX_CHANNELS);

   // Shared 32 by 32 multiplier on magnitudes
   assign xabs = {32'd0, mag32(xhat_ff)};
   assign nmag = mag64(num_ff);

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      case (cmd.msel)
         MUL_DIFF_DY: begin
            mul_a   = mag32(diff_ff);
            mul_b   = mag32(dy_ff);
            mul_neg = diff_ff[31] ^ dy_ff[31];
         end
         MUL_DY_S: begin
            mul_a   = mag32(dy_ff);
            mul_b   = mag32(s_ff);
            mul_neg = dy_ff[31] ^ s_ff[31];
         end
         MUL_X_DY: begin
            mul_a   = mag32(xhat_ff);
            mul_b   = mag32(dy_ff);
            mul_neg = xhat_ff[31] ^ dy_ff[31];
         end
         MUL_QHI_X: begin
            mul_a = qmag_ff[63:32];
            mul_b = xabs[31:0];
         end
         MUL_QLO_X: begin
            mul_a = qmag_ff[31:0];
            mul_b = xabs[31:0];
         end
         MUL_NHI_R: begin
            mul_a = nmag[63:32];
            mul_b = {7'd0, root};
         end
         MUL_NLO_R: begin
            mul_a = nmag[31:0];
            mul_b = {7'd0, root};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff     <= {32'd0, mul_a} * {32'd0, mul_b};
      prod_neg_ff <= mul_neg;
   end

   assign psig = prod_neg_ff ? (~prod_ff + 64'd1) : prod_ff;

   // Shared divider and root units
   assign n_val  = (cnt_ff == '0) ? 32'd1 : 32'(cnt_ff);
   assign div_go = cmd.div_go;

   always_comb begin
      div_dividend = '0;
      div_divisor  = 32'd1;
      unique case (cmd.dsel)
         DIV_XHAT: begin
            div_dividend = {16'd0, mag32(diff_ff), 16'd0};
            div_divisor  = mag32(s_ff);
         end
         DIV_DOTS: begin
            div_dividend = mag64(dots_ff);
            div_divisor  = n_val;
         end
         DIV_DOTB: begin
            div_dividend = mag64(dotb_ff);
            div_divisor  = n_val;
         end
         DIV_ROOT: begin
            div_dividend = 64'h0001_0000_0000_0000;
            div_divisor  = v_ff;
         end
         default: ;
      endcase
   end

   gnb_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_q)
   );

   gnb_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.sqrt_go),
      .radicand (div_q[48:0]),
      .busy     (sqrt_busy),
      .root     (root)
   );

   // Result steps
   always_comb begin
      if (s_ff == '0) begin
         xhat_in = diff_ff;
      end else if (diff_ff[31] ^ s_ff[31]) begin
         xhat_in = (div_q > 64'h0000_0000_8000_0000) ? MIN32 : (~div_q[31:0] + 32'd1);
      end else begin
         xhat_in = (div_q > 64'h0000_0000_7FFF_FFFF) ? MAX32 : div_q[31:0];
      end
   end

   always_comb begin
      logic        neg;
      logic [63:0] lim;
      logic [63:0] mag;
      neg = qneg_ff ^ xhat_ff[31];
      lim = neg ? MIN64 : MAX64;
      if (hi_ff >= 64'h0000_8000_0000_0000) begin
         mag = lim;
      end else begin
         mag = (hi_ff << 16) + (prod_ff >> 16);
         if (mag > lim) begin
            mag = lim;
         end
      end
      t2_in = neg ? (~mag + 64'd1) : mag;
   end

   assign t3_in = dotb_ff[63] ? (~div_q + 64'd1) : div_q;

   always_comb begin
      logic [63:0] mag;
      mag = hi_ff + (prod_ff >> 32);
      if (num_ff[63]) begin
         dx_in = (mag > 64'h0000_0000_8000_0000) ? MIN32 : (~mag[31:0] + 32'd1);
      end else begin
         dx_in = (mag > 64'h0000_0000_7FFF_FFFF) ? MAX32 : mag[31:0];
      end
   end

   assign dx_vz_in = num_ff[63] ? MIN32 : ((num_ff != '0) ? MAX32 : 32'd0);
   assign old_s    = rd_v_ff ? rd_s_ff : 64'd0;
   assign old_b    = rd_v_ff ? rd_b_ff : 64'd0;
   assign dy_q32   = {{16{dy_ff[31]}}, dy_ff, 16'd0};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dx_ff <= '0;
         gs_ff <= '0;
         gb_ff <= '0;
      end
      case (cmd.act)
         ACT_XHAT:     xhat_ff <= xhat_in;
         ACT_TAKE_Q: begin
            qmag_ff <= div_q;
            qneg_ff <= dots_ff[63];
         end
         ACT_HOLD_HI:  hi_ff  <= prod_ff;
         ACT_T2:       t2_ff  <= t2_in;
         ACT_TAKE_T3:  t3_ff  <= t3_in;
         ACT_NUM1:     num_ff <= sat_sub64(psig, t2_ff);
         ACT_NUM2:     num_ff <= sat_sub64(num_ff, t3_ff);
         ACT_DX:       dx_ff  <= dx_in;
         ACT_DX_VZ:    dx_ff  <= dx_vz_in;
         ACT_READ_OUT: begin
            if (ch_ok && rd_v_ff) begin
               gs_ff <= rd_s_ff;
               gb_ff <= rd_b_ff;
            end
         end
         default: ;
      endcase
   end

   // Group sums and element count
   always_ff @(posedge clock) begin
      if (reset) begin
         dots_ff <= '0;
         dotb_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         case (cmd.act)
            ACT_GRP_CLR: begin
               dots_ff <= '0;
               dotb_ff <= '0;
               cnt_ff  <= '0;
            end
            ACT_ACC_DOTS: dots_ff <= sat_add64(dots_ff, psig);
            ACT_ACC_DOTB: begin
               if (use_scale_ff) begin
                  dotb_ff <= sat_add64(dotb_ff, psig);
               end
            end
            ACT_ACC_STORE: begin
               if (cnt_ff < CNTW'(MAX_GROUP_ELEMENTS)) begin
                  cnt_ff <= cnt_ff + CNTW'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // Channel gradient stores
   always_ff @(posedge clock) begin
      if (cmd.act == ACT_ACC_STORE && ch_ok) begin
         scale_mem[idx] <= sat_add64(old_s, psig);
         bias_mem[idx]  <= sat_add64(old_b, dy_q32);
      end
      if (cmd.act == ACT_MEM_RD) begin
         rd_s_ff <= scale_mem[idx];
         rd_b_ff <= bias_mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rd_v_ff <= 1'b0;
      end else begin
         if (cmd.act == ACT_MEM_RD) begin
            rd_v_ff <= vld_ff[idx];
         end
         if (cmd.act == ACT_ACC_STORE && ch_ok) begin
            vld_ff[idx] <= 1'b1;
         end else if (cmd.act == ACT_CH_CLR && ch_ok) begin
            vld_ff[idx] <= 1'b0;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.act == ACT_OUT) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.act == ACT_OUT) begin
         rsp_data_ff <= {gb_ff, gs_ff, dx_ff};
      end
   end

   assign rsp_tvalid         = rsp_vld_ff;
   assign dx_value           = rsp_data_ff[31:0];
   assign channel_grad_scale = rsp_data_ff[95:32];
   assign channel_grad_bias  = rsp_data_ff[159:96];

   assign sts.opcode    = op_ff;
   assign sts.s_zero    = s_ff == '0;
   assign sts.v_zero    = v_ff == '0;
   assign sts.div_busy  = div_busy;
   assign sts.sqrt_busy = sqrt_busy;
   assign sts.out_free  = !rsp_vld_ff || rsp_tready;
endmodule

/* rtl/core/gnb_ctrl.sv */
// Controller state machine: sequences one request through the datapath.
// Depends on gnb_pkg.
module gnb_ctrl import gnb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_tvalid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            unique case (sts.opcode)
               OP_START: state_in = S_GCLR;
               OP_ACCUM, OP_EMIT: state_in = sts.s_zero ? S_XHAT : S_XDIV;
               OP_READ:  state_in = S_RRD;
               OP_CLEAR: state_in = S_CCLR;
               default:  state_in = S_DONE;
            endcase
         end
         S_GCLR:  state_in = S_DONE;
         S_RRD:   state_in = S_ROUT;
         S_ROUT:  state_in = S_DONE;
         S_CCLR:  state_in = S_DONE;
         S_XDIV:  state_in = S_XWAIT;
         S_XWAIT: if (!sts.div_busy) state_in = S_XHAT;
         S_XHAT:  state_in = (sts.opcode == OP_ACCUM) ? S_AM1 : S_EDS;
         S_AM1:   state_in = S_AM2;
         S_AM2:   state_in = S_AM3;
         S_AM3:   state_in = S_AWR;
         S_AWR:   state_in = S_DONE;
         S_EDS:   state_in = S_EWS;
         S_EWS:   if (!sts.div_busy) state_in = S_ETQ;
         S_ETQ:   state_in = S_EM1;
         S_EM1:   state_in = S_EM2;
         S_EM2:   state_in = S_ET2;
         S_ET2:   state_in = S_EDB;
         S_EDB:   state_in = S_EWB;
         S_EWB:   if (!sts.div_busy) state_in = S_ETB;
         S_ETB:   state_in = S_EN1;
         S_EN1:   state_in = S_EN2;
         S_EN2:   state_in = sts.v_zero ? S_EVZ : S_EDR;
         S_EDR:   state_in = S_EWR;
         S_EWR:   if (!sts.div_busy) state_in = S_ESQ;
         S_ESQ:   state_in = S_EWQ;
         S_EWQ:   if (!sts.sqrt_busy) state_in = S_EM4;
         S_EM4:   state_in = S_EM5;
         S_EM5:   state_in = S_EDX;
         S_EDX:   state_in = S_DONE;
         S_EVZ:   state_in = S_DONE;
         S_DONE:  if (sts.out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.load    = 1'b0;
      cmd.act     = ACT_NONE;
      cmd.msel    = MUL_NONE;
      cmd.div_go  = 1'b0;
      cmd.dsel    = DIV_XHAT;
      cmd.sqrt_go = 1'b0;
      req_tready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_GCLR: cmd.act = ACT_GRP_CLR;
         S_RRD:  cmd.act = ACT_MEM_RD;
         S_ROUT: cmd.act = ACT_READ_OUT;
         S_CCLR: cmd.act = ACT_CH_CLR;
         S_XDIV: begin
            cmd.div_go = 1'b1;
            cmd.dsel   = DIV_XHAT;
         end
         S_XHAT: cmd.act = ACT_XHAT;
         S_AM1: begin
            cmd.msel = MUL_DIFF_DY;
            cmd.act  = ACT_MEM_RD;
         end
         S_AM2: begin
            cmd.msel = MUL_DY_S;
            cmd.act  = ACT_ACC_DOTS;
         end
         S_AM3: begin
            cmd.msel = MUL_X_DY;
            cmd.act  = ACT_ACC_DOTB;
         end
         S_AWR: cmd.act = ACT_ACC_STORE;
         S_EDS: begin
            cmd.div_go = 1'b1;
            cmd.dsel   = DIV_DOTS;
         end
         S_ETQ: cmd.act = ACT_TAKE_Q;
         S_EM1: cmd.msel = MUL_QHI_X;
         S_EM2: begin
            cmd.msel = MUL_QLO_X;
            cmd.act  = ACT_HOLD_HI;
         end
         S_ET2: cmd.act = ACT_T2;
         S_EDB: begin
            cmd.div_go = 1'b1;
            cmd.dsel   = DIV_DOTB;
         end
         S_ETB: begin
            cmd.act  = ACT_TAKE_T3;
            cmd.msel = MUL_DY_S;
         end
         S_EN1: cmd.act = ACT_NUM1;
         S_EN2: cmd.act = ACT_NUM2;
         S_EDR: begin
            cmd.div_go = 1'b1;
            cmd.dsel   = DIV_ROOT;
         end
         S_ESQ: cmd.sqrt_go = 1'b1;
         S_EM4: cmd.msel = MUL_NHI_R;
         S_EM5: begin
            cmd.msel = MUL_NLO_R;
            cmd.act  = ACT_HOLD_HI;
         end
         S_EDX: cmd.act = ACT_DX;
         S_EVZ: cmd.act = ACT_DX_VZ;
         S_DONE: if (sts.out_free) cmd.act = ACT_OUT;
         default: ;
      endcase
   end
endmodule

/* rtl/core/group_norm_backward.sv */
// Channel  | Direction | Contents
// req      | in        | tuser: opcode; tdata: y, dy, scale, bias, channel, variance
// rsp      | out       | tdata: dx, channel scale gradient, channel bias gradient
// csr      | in        | epsilon, use_scale, use_bias writes
// One request is in flight at a time. Each request uses the 64-step divider up to four times,
// and emit requests also use the root unit after the last division. A zero scale skips the
// first division, and a zero sum of variance and epsilon skips the last division and the root.
// Reset is synchronous and needs no clearing pass. A waiting result does not block the
// next request, which stalls only at its own result while the output register is full.
// Top level of the group normalisation backward block; depends on gnb_pkg,
// gnb_ctrl, gnb_datapath and group_norm_backward_defines.svh.
`include "group_norm_backward_defines.svh"
module group_norm_backward import gnb_pkg::*; #(
   parameter int MAX_CHANNELS       = MAX_CHANNELS_DEF,
   parameter int MAX_GROUP_ELEMENTS = MAX_GROUP_ELEMENTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [167:0] req_tdata,  // y_value, dy_value, channel_scale, channel_bias,
                                    // channel_index, group_variance, one zero bit
   input  logic [2:0]   req_tuser,  // opcode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,  // dx_value, channel_grad_scale, channel_grad_bias
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   cmd_type     ctl_cmd;
   sts_type     dp_sts;
   logic [31:0] dx_value;
   logic [63:0] channel_grad_scale;
   logic [63:0] channel_grad_bias;

   gnb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (dp_sts),
      .cmd        (ctl_cmd)
   );

   gnb_datapath #(
      .MAX_CHANNELS       (MAX_CHANNELS),
      .MAX_GROUP_ELEMENTS (MAX_GROUP_ELEMENTS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (ctl_cmd),
      .sts                (dp_sts),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .opcode             (req_tuser),
      .y_value            (req_tdata[31:0]),
      .dy_value           (req_tdata[63:32]),
      .channel_scale      (req_tdata[95:64]),
      .channel_bias       (req_tdata[127:96]),
      .channel_index      (req_tdata[135:128]),
      .group_variance     (req_tdata[166:136]),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .dx_value           (dx_value),
      .channel_grad_scale (channel_grad_scale),
      .channel_grad_bias  (channel_grad_bias)
   );

   assign rsp_tdata = {channel_grad_bias, channel_grad_scale, dx_value};

   `GNB_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   `GNB_ASSERT_IMPL(a_out_when_free, clock, reset, ctl_cmd.act == ACT_OUT, dp_sts.out_free)
   `GNB_ASSERT_IMPL(a_div_start_idle, clock, reset, ctl_cmd.div_go, !dp_sts.div_busy)
endmodule
